### rtl/b64e_pkg.sv
package b64e_pkg;

	localparam int LineCharsDef = 76;
	localparam int CharW = 7;
	localparam int QDepth = 2;
	localparam int QCntW = $clog2(QDepth + 1);
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

	localparam logic [CharW-1:0] ChCr = 7'd13;
	localparam logic [CharW-1:0] ChLf = 7'd10;
	localparam logic [CharW-1:0] ChPad = 7'd61;

	localparam logic [1:0] PhStart = 2'd0;
	localparam logic [1:0] PhSecond = 2'd1;
	localparam logic [1:0] PhThird = 2'd2;

	typedef logic [CharW-1:0] char_t;

	// One accepted byte, expanded into the characters it causes.
	typedef struct packed {
		char_t [3:0] chars;
		logic [1:0]  last_idx;
		logic        fin;
	} job_t;

	function automatic char_t b64_sym(input logic [5:0] six);
		char_t res;
		if (six < 6'd26) begin
			res = 7'd65 + {1'b0, six};
		end else if (six < 6'd52) begin
			res = 7'd71 + {1'b0, six};
		end else if (six < 6'd62) begin
			res = {1'b0, six} - 7'd4;
		end else if (six == 6'd62) begin
			res = 7'd43;
		end else begin
			res = 7'd47;
		end
		return res;
	endfunction

endpackage

### rtl/b64e_front.sv
module b64e_front #(
	parameter int LINE_CHARS = b64e_pkg::LineCharsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	input  logic           q_full,
	output logic           push,
	output b64e_pkg::job_t push_job
);
	import b64e_pkg::*;

	localparam logic [6:0] LineLim = 7'(LINE_CHARS);

	logic [1:0] phase_q;
	logic [3:0] held_q;
	logic [6:0] line_q;
	logic [1:0] phase_d;
	logic [3:0] held_d;
	logic [6:0] line_d;
	logic [6:0] line_inc;
	job_t       job;

	assign push = in_valid && !q_full;
	assign line_inc = line_q + 7'd4;

	always_comb begin
		job = '0;
		job.fin = final_byte;
		phase_d = phase_q;
		held_d = held_q;
		line_d = line_q;
		case (phase_q)
			PhSecond: begin
				job.chars[0] = b64_sym({held_q[1:0], data_byte[7:4]});
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[3:0], 2'b00});
					job.chars[2] = ChPad;
					job.last_idx = 2'd2;
				end else begin
					job.last_idx = 2'd0;
					held_d = data_byte[3:0];
					phase_d = PhThird;
				end
			end
			PhThird: begin
				job.chars[0] = b64_sym({held_q, data_byte[7:6]});
				job.chars[1] = b64_sym(data_byte[5:0]);
				if (line_inc == LineLim) begin
					job.chars[2] = ChCr;
					job.chars[3] = ChLf;
					job.last_idx = 2'd3;
					line_d = '0;
				end else begin
					job.last_idx = 2'd1;
					line_d = line_inc;
				end
				held_d = '0;
				phase_d = PhStart;
			end
			default: begin
				job.chars[0] = b64_sym(data_byte[7:2]);
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
					job.chars[2] = ChPad;
					job.chars[3] = ChPad;
					job.last_idx = 2'd3;
				end else begin
					job.last_idx = 2'd0;
					held_d = {2'b00, data_byte[1:0]};
					phase_d = PhSecond;
				end
			end
		endcase
		if (final_byte) begin
			phase_d = PhStart;
			held_d = '0;
			line_d = '0;
		end
	end

	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhStart;
			held_q <= '0;
			line_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			held_q <= held_d;
			line_q <= line_d;
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PhStart || phase_q == PhSecond || phase_q == PhThird)
		else $error("group phase reached an unused value");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && final_byte |=> phase_q == PhStart && line_q == '0)
		else $error("state not cleared after the final byte");
`endif

endmodule

### rtl/b64e_fifo.sv
module b64e_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output b64e_pkg::job_t head_job,
	input  logic           pop
);
	import b64e_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	assign full = cnt_q == QCntW'(QDepth);
	assign head_valid = cnt_q != '0;
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
`endif

endmodule

### rtl/b64e_back.sv
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  b64e_pkg::job_t      head_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [b64e_pkg::CharW-1:0] out_char,
	output logic                run_last,
	output logic                text_end
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       is_last;
	logic       valid_q;
	char_t      char_q;
	logic       run_last_q;
	logic       text_end_q;

	assign load = !valid_q || !out_stall;
	assign is_last = idx_q == head_job.last_idx;
	assign pop = load && head_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			char_q <= head_job.chars[idx_q];
			run_last_q <= is_last;
			text_end_q <= is_last && head_job.fin;
		end
	end

	assign out_valid = valid_q;
	assign out_char = char_q;
	assign run_last = run_last_q;
	assign text_end = text_end_q;

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head_job.last_idx)
		else $error("character index ran past the transaction");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && text_end_q |-> run_last_q)
		else $error("text end flagged on a character that is not last");
`endif

endmodule

### rtl/base64_line_wrapped_encoder.sv
// Streaming Base64 encoder with CR LF line breaks.
// Input channel: one raw byte per transaction on data_byte, with final_byte
// set on the last byte of a message. Output channel: one ASCII character per
// transaction on out_char; run_last marks the last character caused by a byte
// and text_end marks the last character of the message.
// An accepted byte is expanded at once into one to four characters and
// placed in a two-entry queue; the output stage sends one character a cycle
// while out_stall is low. A byte's first character passes from its queue
// entry through the output register before it is presented.
// The queue lets a new byte be accepted while the output stage is still
// sending the characters of earlier ones. Bytes that cause one character
// flow one per cycle while out_stall is low.
// A CR LF pair follows every LINE_CHARS characters of complete groups.
// Reset clears the group position, line count, queue and output register;
// the next byte starts a new message, as does the byte after a final byte.
// While out_stall is high the presented character holds; once the queue
// fills, in_stall rises until a transaction drains.
module base64_line_wrapped_encoder #(
	parameter int LINE_CHARS = b64e_pkg::LineCharsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [b64e_pkg::CharW-1:0] out_char,
	output logic       run_last,
	output logic       text_end
);
	import b64e_pkg::*;

	logic push;
	logic full;
	logic head_valid;
	logic pop;
	job_t push_job;
	job_t head_job;

	assign in_stall = full;

	b64e_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.q_full(full),
		.push(push),
		.push_job(push_job)
	);

	b64e_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.head_valid(head_valid),
		.head_job(head_job),
		.pop(pop)
	);

	b64e_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_job(head_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.run_last(run_last),
		.text_end(text_end)
	);

endmodule
